@@ design/pngrgb_pkg.sv @@
package pngrgb_pkg;

  // Default geometry and storage sizes.
  localparam int DISPLAY_WIDTH_DEF  = 320;
  localparam int DISPLAY_HEIGHT_DEF = 240;
  localparam int PALETTE_DEPTH_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // Column counter saturates here.
  localparam int COLUMN_MAX = 511;

  // Port widths.
  localparam int S_TDATA_W   = 80;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int ADDR_W      = 17;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    MODE_PIXEL     = 2'd0,
    MODE_PAL_COLOR = 2'd1,
    MODE_PAL_ALPHA = 2'd2,
    MODE_NONE      = 2'd3
  } mode_e;

  // PNG colour types.
  typedef enum logic [2:0] {
    TYPE_GRAY       = 3'd0,
    TYPE_RGB        = 3'd2,
    TYPE_PALETTE    = 3'd3,
    TYPE_GRAY_ALPHA = 3'd4,
    TYPE_RGBA       = 3'd6
  } pixel_type_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PIXEL_TYPE  = 3'd0,
    CFG_INDEX_BITS  = 3'd1,
    CFG_HAS_ALPHA   = 3'd2,
    CFG_IMAGE_WIDTH = 3'd3,
    CFG_OFFSET_X    = 3'd4,
    CFG_OFFSET_Y    = 3'd5
  } cfg_index_e;

  // Work kinds passed from the front to the back.
  typedef enum logic [1:0] {
    OP_PIXEL    = 2'd0,
    OP_WR_COLOR = 2'd1,
    OP_WR_ALPHA = 2'd2
  } op_e;

  typedef struct packed {
    logic [2:0] pixel_type;
    logic [3:0] index_bits;
    logic       has_alpha;
    logic [8:0] image_width;
    logic [8:0] offset_x;
    logic [7:0] offset_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pixel_type:  TYPE_RGBA,
    index_bits:  4'd8,
    has_alpha:   1'b0,
    image_width: 9'd320,
    offset_x:    9'd0,
    offset_y:    8'd0
  };

  // One queue entry. For pixel work, data holds {alpha, colour} of a direct
  // colour pixel and idx the packed index byte. For palette writes, data is
  // the value and idx the table entry.
  typedef struct packed {
    op_e                op;
    logic               pal;
    logic [23:0]        data;
    logic [7:0]         idx;
    logic [ADDR_W-1:0]  addr;
    logic [3:0]         cnt;
  } entry_t;

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Log2 of the palette index depth: 8, 4 and 2 are kept, anything else is 1.
  function automatic logic [1:0] index_log2(input logic [3:0] index_bits);
    logic [1:0] lg;
    unique case (index_bits)
      4'd8:    lg = 2'd3;
      4'd4:    lg = 2'd2;
      4'd2:    lg = 2'd1;
      default: lg = 2'd0;
    endcase
    return lg;
  endfunction

  // Index number k of a packed byte, most significant first.
  function automatic logic [7:0] palette_index(input logic [7:0] pbyte, input logic [1:0] lg,
                                               input logic [2:0] k);
    logic [7:0] v;
    logic [7:0] t;
    t = pbyte << {k[1:0], 1'b0};
    unique case (lg)
      2'd3:    v = pbyte;
      2'd2:    v = k[0] ? {4'd0, pbyte[3:0]} : {4'd0, pbyte[7:4]};
      2'd1:    v = {6'd0, t[7:6]};
      default: v = {7'd0, pbyte[3'd7 - k]};
    endcase
    return v;
  endfunction

endpackage

@@ design/png_line_to_rgb565_alpha_top.sv @@
// Channel    | Direction | Handshake                 | Content
// -----------+-----------+---------------------------+--------------------------------------
// s_axis     | in        | s_axis_tvalid/tready      | tuser: mode; tdata: line start, row,
//            |           |                           | pixel data, palette index and value
// m_axis     | out       | m_axis_tvalid/tready      | tdata: address, RGB565, alpha; tlast
// cfg        | in        | cfg_valid/cfg_ready       | register index and write data
//
// The front takes one input transaction per cycle while the queue has room.
// The back spends one cycle per displayed pixel (one to eight per item, set by
// the single palette read port) while the output is not stalled, and one cycle
// per palette write; items with no visible pixel never reach the back. Reset
// clears the column counter and configuration; the palette has no clearing pass.
// Output stalls back up through the queue to s_axis_tready.
module png_line_to_rgb565_alpha_top #(
  parameter int DISPLAY_WIDTH  = pngrgb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = pngrgb_pkg::DISPLAY_HEIGHT_DEF,
  parameter int PALETTE_DEPTH  = pngrgb_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // line_start [0], row [8:1], pixel_data [40:9], palette_index [48:41],
  // palette_value [72:49], zero [79:73]
  input  logic [pngrgb_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // mode [1:0]
  input  logic [pngrgb_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // pixel_address [16:0], color565 [32:17], alpha [40:33], zero [47:41]
  output logic [pngrgb_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pngrgb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [pngrgb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import pngrgb_pkg::*;

  cfg_t   cfg;
  logic   q_push, q_full, q_valid, q_pop;
  entry_t q_in, q_out;

  // Accept, classify and place items.
  pngrgb_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cfg_o           (cfg),
    .q_push_o        (q_push),
    .q_entry_o       (q_in),
    .q_full_i        (q_full)
  );

  // Decoupling queue.
  pngrgb_queue #(
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_out),
    .pop_i   (q_pop)
  );

  // Palette storage, per-pixel expansion and output register.
  pngrgb_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ design/pngrgb_ram.sv @@
module pngrgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pngrgb_front.sv @@
module pngrgb_front #(
  parameter int DISPLAY_WIDTH  = pngrgb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = pngrgb_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [pngrgb_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic [pngrgb_pkg::S_TUSER_W-1:0]     s_axis_tuser_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pngrgb_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [pngrgb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output pngrgb_pkg::cfg_t                     cfg_o,
  output logic                                 q_push_o,
  output pngrgb_pkg::entry_t                   q_entry_o,
  input  logic                                 q_full_i
);

  import pngrgb_pkg::*;

  localparam int LW = ($clog2(DISPLAY_WIDTH + 1) > 10) ? $clog2(DISPLAY_WIDTH + 1) : 10;

  cfg_t        cfg_q;
  logic [8:0]  column_q, column_d;

  mode_e       mode;
  logic        line_start;
  logic [7:0]  row;
  logic [31:0] pdata;
  logic [7:0]  pidx;
  logic [23:0] pval;
  logic        accept;
  logic        pal;
  logic [1:0]  lg;
  logic [3:0]  n;
  logic [8:0]  c0;
  logic [8:0]  y;
  logic        y_ok;
  logic [LW-1:0] x_lim, limit, remain;
  logic [3:0]  cnt;
  logic [9:0]  col_sum;
  logic [7:0]  r, g, b, a;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PIXEL_TYPE:  cfg_q.pixel_type  <= cfg_data_i[2:0];
        CFG_INDEX_BITS:  cfg_q.index_bits  <= cfg_data_i[3:0];
        CFG_HAS_ALPHA:   cfg_q.has_alpha   <= cfg_data_i[0];
        CFG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data_i[8:0];
        CFG_OFFSET_X:    cfg_q.offset_x    <= cfg_data_i[8:0];
        CFG_OFFSET_Y:    cfg_q.offset_y    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transaction.
  assign mode       = mode_e'(s_axis_tuser_i[1:0]);
  assign line_start = s_axis_tdata_i[0];
  assign row        = s_axis_tdata_i[8:1];
  assign pdata      = s_axis_tdata_i[40:9];
  assign pidx       = s_axis_tdata_i[48:41];
  assign pval       = s_axis_tdata_i[72:49];

  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && !q_full_i;

  // Pixels per item and the run of them that lands on the display. Emitted
  // pixels always form a prefix of the item, so a count is enough.
  assign pal  = (cfg_q.pixel_type == TYPE_PALETTE);
  assign lg   = index_log2(cfg_q.index_bits);
  assign n    = pal ? (4'd8 >> lg) : 4'd1;
  assign c0   = line_start ? 9'd0 : column_q;
  assign y    = {1'b0, row} + {1'b0, cfg_q.offset_y};
  assign y_ok = 32'(y) < 32'(DISPLAY_HEIGHT);

  always_comb begin
    x_lim  = (LW'(cfg_q.offset_x) < LW'(DISPLAY_WIDTH)) ?
             LW'(DISPLAY_WIDTH) - LW'(cfg_q.offset_x) : '0;
    limit  = (LW'(cfg_q.image_width) < x_lim) ? LW'(cfg_q.image_width) : x_lim;
    remain = (limit > LW'(c0)) ? limit - LW'(c0) : '0;
    if (!y_ok) begin
      cnt = 4'd0;
    end else if (remain < LW'(n)) begin
      cnt = 4'(remain);
    end else begin
      cnt = n;
    end
  end

  // Column advances by every source pixel and saturates.
  assign col_sum  = {1'b0, c0} + 10'(n);
  assign column_d = (col_sum > 10'(COLUMN_MAX)) ? 9'(COLUMN_MAX) : col_sum[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
    end else if (accept && mode == MODE_PIXEL) begin
      column_q <= column_d;
    end
  end

  // Direct colour pixels are converted here; palette ones in the back.
  always_comb begin
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    a = 8'd0;
    unique case (pixel_type_e'(cfg_q.pixel_type))
      TYPE_RGBA: begin
        r = pdata[7:0];
        g = pdata[15:8];
        b = pdata[23:16];
        a = pdata[31:24];
      end
      TYPE_RGB: begin
        r = pdata[7:0];
        g = pdata[15:8];
        b = pdata[23:16];
        a = 8'hFF;
      end
      TYPE_GRAY_ALPHA: begin
        r = pdata[7:0];
        g = pdata[7:0];
        b = pdata[7:0];
        a = pdata[15:8];
      end
      TYPE_GRAY: begin
        r = pdata[7:0];
        g = pdata[7:0];
        b = pdata[7:0];
        a = 8'hFF;
      end
      default: ;
    endcase
  end

  // Build the queue entry.
  always_comb begin
    q_entry_o.op   = OP_PIXEL;
    q_entry_o.pal  = pal;
    q_entry_o.data = {a, pack565(r, g, b)};
    q_entry_o.idx  = pdata[7:0];
    q_entry_o.addr = ADDR_W'(32'(y) * 32'(DISPLAY_WIDTH) + 32'(cfg_q.offset_x) + 32'(c0));
    q_entry_o.cnt  = cnt;
    q_push_o       = 1'b0;
    unique case (mode)
      MODE_PIXEL: begin
        q_push_o = accept && (cnt != 4'd0);
      end
      MODE_PAL_COLOR: begin
        q_entry_o.op   = OP_WR_COLOR;
        q_entry_o.data = pval;
        q_entry_o.idx  = pidx;
        q_push_o       = accept;
      end
      MODE_PAL_ALPHA: begin
        q_entry_o.op   = OP_WR_ALPHA;
        q_entry_o.data = pval;
        q_entry_o.idx  = pidx;
        q_push_o       = accept;
      end
      default: ;
    endcase
  end

endmodule

@@ design/pngrgb_queue.sv @@
module pngrgb_queue #(
  parameter int DEPTH = pngrgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pngrgb_pkg::entry_t entry_i,
  output logic               full_o,
  output logic               valid_o,
  output pngrgb_pkg::entry_t entry_o,
  input  logic               pop_i
);

  import pngrgb_pkg::*;

  // User sets DEPTH to a power of two, at least two (unchecked); pointers wrap.
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ design/pngrgb_back.sv @@
module pngrgb_back #(
  parameter int PALETTE_DEPTH = pngrgb_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pngrgb_pkg::cfg_t                 cfg_i,
  input  logic                             q_valid_i,
  input  pngrgb_pkg::entry_t               q_entry_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [pngrgb_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  import pngrgb_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [2:0]        k_q;
  logic              sb_valid_q;
  logic [ADDR_W-1:0] sb_addr_q;
  logic              sb_pal_q;
  logic              sb_in_range_q;
  logic [23:0]       sb_data_q;
  logic              sb_last_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [15:0]       out_color_q;
  logic [7:0]        out_alpha_q;
  logic              out_last_q;

  logic              out_free, sb_free;
  logic              is_pix, is_wr, issue, last_k;
  logic [7:0]        v;
  logic              rd_in_range, wr_in_range;
  logic              we_color, we_alpha;
  logic [23:0]       color_rd, rgb;
  logic [7:0]        alpha_rd;
  logic [15:0]       color_d;
  logic [7:0]        alpha_d;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign sb_free  = !sb_valid_q || out_free;

  // Issue one pixel of the head entry per cycle while the stage ahead is free; palette writes pop at once.
  assign is_pix  = q_valid_i && (q_entry_i.op == OP_PIXEL);
  assign is_wr   = q_valid_i && (q_entry_i.op != OP_PIXEL);
  assign issue   = is_pix && sb_free;
  assign last_k  = ((4'(k_q) + 4'd1) == q_entry_i.cnt);
  assign q_pop_o = is_wr || (issue && last_k);

  assign v           = palette_index(q_entry_i.idx, index_log2(cfg_i.index_bits), k_q);
  assign rd_in_range = {1'b0, v} < 9'(PALETTE_DEPTH);
  assign wr_in_range = {1'b0, q_entry_i.idx} < 9'(PALETTE_DEPTH);
  assign we_color    = is_wr && (q_entry_i.op == OP_WR_COLOR) && wr_in_range;
  assign we_alpha    = is_wr && (q_entry_i.op == OP_WR_ALPHA) && wr_in_range;

  pngrgb_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (we_color),
    .waddr_i (q_entry_i.idx[AW-1:0]),
    .wdata_i (q_entry_i.data),
    .re_i    (issue),
    .raddr_i (v[AW-1:0]),
    .rdata_o (color_rd)
  );

  pngrgb_ram #(
    .WIDTH (8),
    .DEPTH (PALETTE_DEPTH)
  ) u_alpha_ram (
    .clk_i   (clk_i),
    .we_i    (we_alpha),
    .waddr_i (q_entry_i.idx[AW-1:0]),
    .wdata_i (q_entry_i.data[7:0]),
    .re_i    (issue),
    .raddr_i (v[AW-1:0]),
    .rdata_o (alpha_rd)
  );

  // Pixel counter within the head entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (issue) begin
      k_q <= last_k ? 3'd0 : k_q + 3'd1;
    end
  end

  // Stage waiting for the palette read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q <= 1'b0;
    end else if (issue) begin
      sb_valid_q <= 1'b1;
    end else if (out_free) begin
      sb_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      sb_addr_q     <= q_entry_i.addr + ADDR_W'(k_q);
      sb_pal_q      <= q_entry_i.pal;
      sb_in_range_q <= rd_in_range;
      sb_data_q     <= q_entry_i.data;
      sb_last_q     <= last_k;
    end
  end

  // Final colour; entries beyond the palette read as black, transparent when has_alpha is set.
  always_comb begin
    rgb = sb_in_range_q ? color_rd : 24'd0;
    if (sb_pal_q) begin
      color_d = pack565(rgb[23:16], rgb[15:8], rgb[7:0]);
      alpha_d = cfg_i.has_alpha ? (sb_in_range_q ? alpha_rd : 8'd0) : 8'hFF;
    end else begin
      color_d = sb_data_q[15:0];
      alpha_d = sb_data_q[23:16];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= sb_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && sb_valid_q) begin
      out_addr_q  <= sb_addr_q;
      out_color_q <= color_d;
      out_alpha_q <= alpha_d;
      out_last_q  <= sb_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_alpha_q, out_color_q, out_addr_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ design/pngrgb_checker.sv @@
module pngrgb_checker #(
  parameter int DISPLAY_WIDTH  = pngrgb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = pngrgb_pkg::DISPLAY_HEIGHT_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [pngrgb_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  input logic                               m_axis_tlast_o
);

  import pngrgb_pkg::*;

  localparam int AREA = DISPLAY_WIDTH * DISPLAY_HEIGHT;

  logic              exp_valid_q;
  logic [ADDR_W-1:0] exp_addr_q;
  logic [ADDR_W-1:0] addr;

  assign addr = m_axis_tdata_o[ADDR_W-1:0];

  // Within one item the displayed pixels sit at consecutive addresses.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_valid_q <= 1'b0;
      exp_addr_q  <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      exp_valid_q <= !m_axis_tlast_o;
      exp_addr_q  <= addr + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  a_addr_on_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (AREA > (1 << ADDR_W)) || (32'(addr) < 32'(AREA)))
    else $error("pixel address outside the display");

  a_addr_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && exp_valid_q |-> addr == exp_addr_q)
    else $error("pixels of one item are not at consecutive addresses");

  // A reset edge leaves the output idle for the following cycle.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind png_line_to_rgb565_alpha_top pngrgb_checker #(
  .DISPLAY_WIDTH  (DISPLAY_WIDTH),
  .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
) u_pngrgb_checker (.*);

@@ tb/tb_png_line_to_rgb565_alpha_top.sv @@
`timescale 1ns / 100ps

module tb_png_line_to_rgb565_alpha_top;
  import pngrgb_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 260;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DISP_W         = DISPLAY_WIDTH_DEF;
  localparam int DISP_H         = DISPLAY_HEIGHT_DEF;

  // Colour type codes that the block does not know.
  localparam logic [2:0] TYPE_UNDEF_1 = 3'd1;
  localparam logic [2:0] TYPE_UNDEF_5 = 3'd5;
  localparam logic [2:0] TYPE_UNDEF_7 = 3'd7;

  typedef struct packed {
    mode_e       mode;
    logic        line_start;
    logic [7:0]  row;
    logic [31:0] pixel_data;
    logic [7:0]  pal_index;
    logic [23:0] pal_value;
  } stream_item_t;

  typedef struct packed {
    logic [16:0] address;
    logic [15:0] color;
    logic [7:0]  alpha;
    logic        last;
  } disp_write_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [S_TDATA_W-1:0]   s_axis_tdata_i  = '0;
  logic [S_TUSER_W-1:0]   s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;
  logic                   m_axis_tlast_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;

  // Stimulus waiting to be sent and display writes waiting to arrive.
  stream_item_t stream_items[$];
  disp_write_t  pending_writes[$];

  // Shadow copy of the block's state and registers.
  cfg_t        cfg_model = CFG_RESET;
  logic [23:0] pal_color[256];
  logic [7:0]  pal_alpha[256];
  int          column = 0;

  // Palette entries already loaded by the stimulus.
  bit          pal_has_color[256];
  bit          pal_has_alpha[256];
  bit          pal_listed[256];
  logic [7:0]  pal_ready[$];

  stream_item_t cur_item;
  int          n_items     = 0;
  int          n_errors    = 0;
  int          drv_gap     = 0;
  bit          drv_quiet   = 1'b0;
  int          mon_stall   = 0;
  bit          mon_quiet   = 1'b0;
  int          idle_cycles = 0;

  png_line_to_rgb565_alpha_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_item(input mode_e m, input logic ls, input logic [7:0] row,
                                     input logic [31:0] data, input logic [7:0] pidx,
                                     input logic [23:0] pval);
    stream_item_t it;
    it.mode       = m;
    it.line_start = ls;
    it.row        = row;
    it.pixel_data = data;
    it.pal_index  = pidx;
    it.pal_value  = pval;
    stream_items.push_back(it);
    if (m == MODE_PAL_COLOR) pal_has_color[pidx] = 1'b1;
    if (m == MODE_PAL_ALPHA) pal_has_alpha[pidx] = 1'b1;
    // An entry may be read only once both of its tables hold a value.
    if (pal_has_color[pidx] && pal_has_alpha[pidx] && !pal_listed[pidx]) begin
      pal_listed[pidx] = 1'b1;
      pal_ready.push_back(pidx);
    end
    if (m != MODE_NONE) n_items++;
  endfunction

  function automatic void queue_pixel(input logic ls, input logic [7:0] row,
                                      input logic [31:0] data);
    queue_item(MODE_PIXEL, ls, row, data, 8'($urandom), 24'($urandom));
  endfunction

  function automatic void queue_palette(input mode_e m, input logic [7:0] pidx,
                                        input logic [23:0] pval);
    queue_item(m, 1'($urandom), 8'($urandom), $urandom, pidx, pval);
  endfunction

  // Works out the display writes that one accepted transaction causes.
  task automatic predict_writes(input stream_item_t it);
    disp_write_t batch[$];
    disp_write_t w;
    int          bits, n, y, col, sh, idx, k;
    logic [7:0]  r, g, b, a;
    logic [23:0] rgb;
    begin
      case (it.mode)
        MODE_PAL_COLOR: pal_color[it.pal_index] = it.pal_value;
        MODE_PAL_ALPHA: pal_alpha[it.pal_index] = it.pal_value[7:0];
        MODE_PIXEL: begin
          if (it.line_start) column = 0;
          y = int'(it.row) + int'(cfg_model.offset_y);
          bits = (cfg_model.index_bits == 4'd8 || cfg_model.index_bits == 4'd4 ||
                  cfg_model.index_bits == 4'd2) ? int'(cfg_model.index_bits) : 1;
          n = (cfg_model.pixel_type == TYPE_PALETTE) ? 8 / bits : 1;
          for (k = 0; k < n; k++) begin
            r = '0;
            g = '0;
            b = '0;
            a = '0;
            col = column;
            case (cfg_model.pixel_type)
              TYPE_RGBA: {a, b, g, r} = it.pixel_data;
              TYPE_RGB: begin
                {b, g, r} = it.pixel_data[23:0];
                a = 8'hFF;
              end
              TYPE_GRAY_ALPHA: begin
                r = it.pixel_data[7:0];
                g = r;
                b = r;
                a = it.pixel_data[15:8];
              end
              TYPE_GRAY: begin
                r = it.pixel_data[7:0];
                g = r;
                b = r;
                a = 8'hFF;
              end
              TYPE_PALETTE: begin
                // Indices are packed most significant first.
                sh = 8 - bits * (k + 1);
                idx = (int'(it.pixel_data[7:0]) >> sh) & ((1 << bits) - 1);
                rgb = pal_color[idx];
                {r, g, b} = rgb;
                a = cfg_model.has_alpha ? pal_alpha[idx] : 8'hFF;
              end
              default: ;
            endcase
            if (col < int'(cfg_model.image_width) &&
                int'(cfg_model.offset_x) + col < DISP_W && y < DISP_H) begin
              w.address = 17'(y * DISP_W + int'(cfg_model.offset_x) + col);
              w.color   = {r[7:3], g[7:2], b[7:3]};
              w.alpha   = a;
              w.last    = 1'b0;
              batch.push_back(w);
            end
            // Dropped pixels still move the column on; it saturates.
            if (column < COLUMN_MAX) column++;
          end
          if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
          foreach (batch[i]) pending_writes.push_back(batch[i]);
        end
        default: ;
      endcase
    end
  endtask

  function automatic void field_check(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Waits until everything sent has been answered, then lets the block settle.
  task automatic wait_idle();
    begin
      do @(posedge clk_i);
      while (stream_items.size() != 0 || s_axis_tvalid_i || pending_writes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end
  endtask

  // One register write; the caller lowers the valid after its last write.
  task automatic cfg_write(input cfg_index_e idx, input logic [8:0] val);
    begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do @(posedge clk_i);
      while (!cfg_ready_o);
      case (idx)
        CFG_PIXEL_TYPE:  cfg_model.pixel_type  = val[2:0];
        CFG_INDEX_BITS:  cfg_model.index_bits  = val[3:0];
        CFG_HAS_ALPHA:   cfg_model.has_alpha   = val[0];
        CFG_IMAGE_WIDTH: cfg_model.image_width = val;
        CFG_OFFSET_X:    cfg_model.offset_x    = val;
        CFG_OFFSET_Y:    cfg_model.offset_y    = val[7:0];
        default: ;
      endcase
    end
  endtask

  task automatic set_config(input logic [2:0] ptype, input logic [3:0] ibits, input logic ha,
                            input logic [8:0] w, input logic [8:0] ox, input logic [7:0] oy);
    begin
      wait_idle();
      cfg_write(CFG_PIXEL_TYPE, 9'(ptype));
      cfg_write(CFG_INDEX_BITS, 9'(ibits));
      cfg_write(CFG_HAS_ALPHA, 9'(ha));
      cfg_write(CFG_IMAGE_WIDTH, w);
      cfg_write(CFG_OFFSET_X, ox);
      cfg_write(CFG_OFFSET_Y, 9'(oy));
      cfg_valid_i <= 1'b0;
    end
  endtask

  // Input driver: sends queued transactions with random gaps between them.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_writes(cur_item);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (stream_items.size() > 0) begin
          cur_item = stream_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {7'd0, cur_item.pal_value, cur_item.pal_index,
                              cur_item.pixel_data, cur_item.row, cur_item.line_start};
          s_axis_tuser_i  <= cur_item.mode;
          if ($urandom_range(0, 63) == 0) drv_quiet = !drv_quiet;
          drv_gap = drv_quiet ? 0 : idle_len();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each display write and stalls the output at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected display write: tdata 0x%0h, tlast %0b",
               m_axis_tdata_o, m_axis_tlast_o);
        n_errors++;
      end else begin
        disp_write_t want;
        want = pending_writes.pop_front();
        field_check("pixel_address", 32'(want.address), 32'(m_axis_tdata_o[16:0]));
        field_check("color565", 32'(want.color), 32'(m_axis_tdata_o[32:17]));
        field_check("alpha", 32'(want.alpha), 32'(m_axis_tdata_o[40:33]));
        field_check("last_of_item", 32'(want.last), 32'(m_axis_tlast_o));
      end
    end
    if (mon_stall > 0) begin
      mon_stall--;
      m_axis_tready_i <= 1'b0;
    end else if (!mon_quiet && $urandom_range(0, 3) == 0) begin
      mon_stall = idle_len();
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
    if ($urandom_range(0, 255) == 0) mon_quiet = !mon_quiet;
  end

  // Watchdog on cycles in which no transaction moves on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          r, k, line, nlines, len, cap, row_i, bits_eff, ppi, t;
    logic [2:0]  ptype;
    logic [3:0]  ibits;
    logic        ha, ls;
    logic [8:0]  w, ox;
    logic [7:0]  oy;
    logic [31:0] d;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset settings: RGBA, full width, no offsets; the unused mode is ignored.
    queue_pixel(1'b1, 8'd0, 32'h0000_0000);
    queue_pixel(1'b0, 8'd0, 32'hFFFF_FFFF);
    queue_pixel(1'b1, 8'd239, 32'h8040_C020);
    queue_item(MODE_NONE, 1'b1, 8'd7, $urandom, 8'($urandom), 24'($urandom));

    // Offsets at their maximum: only the very first pixel lands on the display.
    set_config(TYPE_RGB, 4'd8, 1'b1, 9'd320, 9'd319, 8'd239);
    queue_pixel(1'b1, 8'd0, $urandom);
    queue_pixel(1'b0, 8'd0, $urandom);
    queue_pixel(1'b1, 8'd1, $urandom);

    // Single-pixel image width: the second pixel of the line is dropped.
    set_config(TYPE_GRAY_ALPHA, 4'd4, 1'b0, 9'd1, 9'd0, 8'd0);
    queue_pixel(1'b1, 8'd5, 32'hFFFF_00FF);
    queue_pixel(1'b0, 8'd5, $urandom);

    set_config(TYPE_GRAY, 4'd2, 1'b1, 9'd320, 9'd10, 8'd20);
    queue_pixel(1'b1, 8'd100, $urandom);

    // An unknown colour type gives one transparent black pixel.
    set_config(TYPE_UNDEF_5, 4'd1, 1'b0, 9'd320, 9'd0, 8'd0);
    queue_pixel(1'b1, 8'd3, 32'hFFFF_FFFF);

    // Palette entries at both ends of the value range, plus the last entry.
    queue_palette(MODE_PAL_COLOR, 8'd0, 24'h00_0000);
    queue_palette(MODE_PAL_ALPHA, 8'd0, 24'hFFFF_00);
    queue_palette(MODE_PAL_COLOR, 8'd1, 24'hFF_FFFF);
    queue_palette(MODE_PAL_ALPHA, 8'd1, 24'h0000_FF);
    queue_palette(MODE_PAL_COLOR, 8'd2, 24'($urandom));
    queue_palette(MODE_PAL_ALPHA, 8'd2, 24'($urandom));
    queue_palette(MODE_PAL_COLOR, 8'd3, 24'($urandom));
    queue_palette(MODE_PAL_ALPHA, 8'd3, 24'($urandom));
    queue_palette(MODE_PAL_COLOR, 8'd255, 24'hA5_C3E7);
    queue_palette(MODE_PAL_ALPHA, 8'd255, 24'h5A_3C80);

    // One-bit indices with a width that ends inside the byte, then a byte
    // with no visible pixel at all.
    set_config(TYPE_PALETTE, 4'd1, 1'b1, 9'd5, 9'd0, 8'd0);
    queue_pixel(1'b1, 8'd7, {24'($urandom), 8'hA5});
    queue_pixel(1'b0, 8'd7, $urandom);

    // Two-bit indices running off the right edge of the display.
    set_config(TYPE_PALETTE, 4'd2, 1'b0, 9'd320, 9'd316, 8'd0);
    queue_pixel(1'b1, 8'd9, {24'($urandom), 8'h1B});
    queue_pixel(1'b0, 8'd9, {24'($urandom), 8'hE4});

    set_config(TYPE_PALETTE, 4'd4, 1'b1, 9'd320, 9'd0, 8'd0);
    queue_pixel(1'b1, 8'd2, {24'($urandom), 8'h30});

    set_config(TYPE_PALETTE, 4'd8, 1'b1, 9'd320, 9'd0, 8'd0);
    queue_pixel(1'b1, 8'd239, {24'($urandom), 8'hFF});
    queue_pixel(1'b0, 8'd239, {24'($urandom), 8'h01});

    // An unsupported depth behaves as one bit per index.
    set_config(TYPE_PALETTE, 4'd3, 1'b0, 9'd320, 9'd0, 8'd0);
    queue_pixel(1'b1, 8'd4, {24'($urandom), 8'h6C});

    // Load the rest of the entries that packed indices can reach.
    for (k = 4; k < 16; k++) begin
      queue_palette(MODE_PAL_COLOR, 8'(k), 24'($urandom));
      queue_palette(MODE_PAL_ALPHA, 8'(k), 24'($urandom));
    end

    // Random phases: a fresh setting, then a few scanlines with random content.
    while (n_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        4:       ptype = TYPE_RGBA;
        5:       ptype = TYPE_RGB;
        6:       ptype = TYPE_GRAY_ALPHA;
        7:       ptype = TYPE_GRAY;
        8: begin
          case ($urandom_range(0, 2))
            0:       ptype = TYPE_UNDEF_1;
            1:       ptype = TYPE_UNDEF_5;
            default: ptype = TYPE_UNDEF_7;
          endcase
        end
        default: ptype = TYPE_PALETTE;
      endcase
      ibits = 4'($urandom_range(1, 8));
      ha    = 1'($urandom);
      case ($urandom_range(0, 9))
        0:       w = 9'd1;
        1:       w = 9'd320;
        2:       w = 9'($urandom_range(1, 320));
        default: w = 9'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0:       ox = 9'd0;
        1:       ox = 9'd319;
        2: begin
          // Image ends right at the display edge or just past it.
          t = 320 - int'(w) + $urandom_range(0, 2);
          ox = 9'((t > 319) ? 319 : t);
        end
        3, 4, 5: ox = 9'($urandom_range(0, 319));
        default: ox = 9'($urandom_range(0, 16));
      endcase
      case ($urandom_range(0, 9))
        0:       oy = 8'd0;
        1:       oy = 8'd239;
        2, 3:    oy = 8'($urandom_range(0, 239));
        default: oy = 8'($urandom_range(0, 8));
      endcase
      set_config(ptype, ibits, ha, w, ox, oy);

      bits_eff = (ibits == 4'd8 || ibits == 4'd4 || ibits == 4'd2) ? int'(ibits) : 1;
      ppi = (ptype == TYPE_PALETTE) ? 8 / bits_eff : 1;
      nlines = $urandom_range(1, 4);
      row_i = $urandom_range(0, 239);
      for (line = 0; line < nlines; line++) begin
        len = (int'(w) + ppi - 1) / ppi + $urandom_range(0, 1);
        cap = $urandom_range(2, 10);
        if (len > cap) len = cap;
        // Now and then a line starts without its marker.
        ls = ($urandom_range(0, 7) != 0);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            r = $urandom_range(0, 2);
            if (r == 0)
              queue_item(MODE_NONE, 1'($urandom), 8'($urandom), $urandom, 8'($urandom),
                         24'($urandom));
            else
              queue_palette((r == 1) ? MODE_PAL_COLOR : MODE_PAL_ALPHA, 8'($urandom),
                            24'($urandom));
          end
          d = $urandom;
          if (ptype == TYPE_PALETTE && bits_eff == 8)
            d[7:0] = pal_ready[$urandom_range(0, pal_ready.size() - 1)];
          queue_pixel((k == 0) ? ls : ($urandom_range(0, 31) == 0), 8'(row_i), d);
        end
        row_i = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 239) : (row_i + 1) % 240;
      end
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
